// ===== src/picture_clause_analyzer_unit_defines.svh =====
// Assertion macros for the picture clause analyzer.
// Taken in by the top level; depends on nothing else.
`ifndef PICTURE_CLAUSE_ANALYZER_UNIT_DEFINES_SVH
`define PICTURE_CLAUSE_ANALYZER_UNIT_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define PCA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define PCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/pca_pkg.sv =====
// Shared types and character codes of the picture clause analyzer.
// No dependencies; used by every module of the block.
package pca_pkg;

   // Character codes after case folding
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_X       = 8'h58;
   localparam logic [7:0] CHAR_A       = 8'h41;
   localparam logic [7:0] CHAR_Z       = 8'h5A;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_S       = 8'h53;
   localparam logic [7:0] CHAR_V       = 8'h56;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // Bit positions of the three counts in a group mask
   localparam int GRP_DIG = 0;
   localparam int GRP_SCL = 1;
   localparam int GRP_LET = 2;

   typedef enum logic [1:0] {
      KIND_UNKNOWN = 2'd0,
      KIND_ALNUM   = 2'd1,
      KIND_NUMERIC = 2'd2,
      KIND_FLOAT   = 2'd3
   } kind_type;

   // Decoded symbol
   typedef struct packed {
      logic       is_end;
      logic       is_digit;
      logic       is_nine;
      logic       is_letter;
      logic       is_numeric;
      logic       is_point;
      logic       is_open;
      logic       is_close;
      logic [3:0] digit;
   } sym_class_type;

   // What the pending repeat group does with the current symbol
   typedef struct packed {
      logic [2:0] held_mask;
      logic       digit;
      logic       accept;
      logic       replay;
      logic       full;
      logic       run_ends_nine;
   } grp_event_type;

endpackage

// ===== src/pca_symbol_decode.sv =====
// Symbol decoder: folds lower case to upper and classifies one byte.
// Depends on pca_pkg.
module pca_symbol_decode (
   input  logic [7:0]             symbol,
   output pca_pkg::sym_class_type cls
);
   import pca_pkg::*;

   logic [7:0] folded;

   // Fold case, then match the picture symbols
   always_comb begin
      folded = symbol;
      if (symbol inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         folded = symbol - CASE_OFFSET;
      end
      cls.is_end     = (symbol == CHAR_NUL);
      cls.is_digit   = (folded inside {[CHAR_ZERO:CHAR_NINE]});
      cls.is_nine    = (folded == CHAR_NINE);
      cls.is_letter  = (folded inside {CHAR_X, CHAR_A, CHAR_Z});
      cls.is_numeric = (folded inside {CHAR_NINE, CHAR_S, CHAR_V});
      cls.is_point   = (folded == CHAR_V);
      cls.is_open    = (folded == CHAR_LPAREN);
      cls.is_close   = (folded == CHAR_RPAREN);
      cls.digit      = 4'(folded - CHAR_ZERO);
   end

endmodule

// ===== src/pca_repeat_group.sv =====
// Pending repeat group: tracks an open "(", accumulates the repeat value
// and the nines held back until ")" decides. Depends on pca_pkg.
module pca_repeat_group #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  pca_pkg::sym_class_type     cls,
   input  logic [2:0]                 opened,
   output pca_pkg::grp_event_type     ev,
   output logic [COUNT_WIDTH-1:0]     extra,
   output logic [COUNT_WIDTH-1:0]     run_nines
);
   import pca_pkg::*;

   localparam int WIDE = COUNT_WIDTH + 4;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

   logic [2:0]             group_open_ff, group_open_in;
   logic [COUNT_WIDTH-1:0] accum_ff, accum_in;
   logic                   has_digit_ff, has_digit_in;
   logic [COUNT_WIDTH-1:0] run_nines_ff, run_nines_in;
   logic                   run_ends_ff, run_ends_in;
   logic [WIDE-1:0]        scaled;
   logic                   accum_sat;
   logic                   active, is_dig, is_acc;

   // Classify the symbol against the pending group
   always_comb begin
      active    = |group_open_ff;
      is_dig    = active && cls.is_digit;
      is_acc    = active && cls.is_close && has_digit_ff;
      ev.held_mask     = group_open_ff;
      ev.digit         = is_dig;
      ev.accept        = is_acc;
      ev.replay        = active && !is_dig && !is_acc;
      ev.full          = (accum_ff == CNT_MAX);
      ev.run_ends_nine = run_ends_ff;
      extra     = (accum_ff == '0) ? '0 : accum_ff - CNT_ONE;
      run_nines = run_nines_ff;
   end

   // Base ten accumulate: acc * 8 + acc * 2 + digit
   always_comb begin
      scaled = ({4'b0000, accum_ff} << 3) + ({4'b0000, accum_ff} << 1)
             + (WIDE)'(cls.digit);
      accum_sat = |scaled[WIDE-1:COUNT_WIDTH];
   end

   // Next group state
   always_comb begin
      group_open_in = group_open_ff;
      accum_in      = accum_ff;
      has_digit_in  = has_digit_ff;
      run_nines_in  = run_nines_ff;
      run_ends_in   = run_ends_ff;
      if (|opened) begin
         group_open_in = opened;
         accum_in      = '0;
         has_digit_in  = 1'b0;
         run_nines_in  = '0;
         run_ends_in   = 1'b0;
      end else if (is_dig) begin
         accum_in     = accum_sat ? CNT_MAX : scaled[COUNT_WIDTH-1:0];
         has_digit_in = 1'b1;
         if (cls.is_nine && run_nines_ff != CNT_MAX) begin
            run_nines_in = run_nines_ff + CNT_ONE;
         end
         run_ends_in = cls.is_nine;
      end else if (active) begin
         group_open_in = '0;
      end
   end

   // Hold the open mask; clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         group_open_ff <= '0;
      end else if (step) begin
         group_open_ff <= group_open_in;
      end
   end

   // Held group data, only read while a group is open
   always_ff @(posedge clock) begin
      if (step) begin
         accum_ff     <= accum_in;
         has_digit_ff <= has_digit_in;
         run_nines_ff <= run_nines_in;
         run_ends_ff  <= run_ends_in;
      end
   end

endmodule

// ===== src/pca_tally.sv =====
// Running counts, kind flags and saturation for one picture string.
// Applies the group events from pca_repeat_group. Depends on pca_pkg.
module pca_tally #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  pca_pkg::sym_class_type     cls,
   input  pca_pkg::grp_event_type     ev,
   input  logic [COUNT_WIDTH-1:0]     extra,
   input  logic [COUNT_WIDTH-1:0]     run_nines,
   output logic [2:0]                 opened,
   output pca_pkg::kind_type          kind,
   output logic [COUNT_WIDTH-1:0]     digit_total,
   output logic [COUNT_WIDTH-1:0]     scale_total,
   output logic [COUNT_WIDTH-1:0]     letter_total,
   output logic                       saturated
);
   import pca_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

   logic                   letter_seen_ff, digit_seen_ff, point_seen_ff;
   logic [COUNT_WIDTH-1:0] digit_ff, scale_ff, letter_ff;
   logic                   after_point_ff, after_point_in;
   logic                   prev_dig_ff, prev_dig_in;
   logic                   prev_scl_ff, prev_scl_in;
   logic                   prev_let_ff, prev_let_in;
   logic                   flag_ff, flag_in;

   logic                   plain_d, plain_s, plain_l;
   logic                   rep_d, rep_s, acc_d, acc_s, acc_l;
   logic                   pd_eff, ps_eff, pl_eff;
   logic [COUNT_WIDTH-1:0] add_d, add_s, add_l;
   logic [COUNT_WIDTH:0]   sum_d, sum_s, sum_l;
   logic                   sat_d, sat_s, sat_l;

   // Decide which path each count takes for this symbol
   always_comb begin
      plain_d = ev.replay || !ev.held_mask[GRP_DIG];
      plain_s = ev.replay || !ev.held_mask[GRP_SCL];
      plain_l = ev.replay || !ev.held_mask[GRP_LET];
      rep_d   = ev.replay && ev.held_mask[GRP_DIG];
      rep_s   = ev.replay && ev.held_mask[GRP_SCL];
      acc_d   = ev.accept && ev.held_mask[GRP_DIG];
      acc_s   = ev.accept && ev.held_mask[GRP_SCL];
      acc_l   = ev.accept && ev.held_mask[GRP_LET];
      pd_eff  = rep_d ? ev.run_ends_nine : prev_dig_ff;
      ps_eff  = rep_s ? ev.run_ends_nine : prev_scl_ff;
      pl_eff  = ev.replay && ev.held_mask[GRP_LET] ? 1'b0 : prev_let_ff;
   end

   // Select one addend per count
   always_comb begin
      add_d = '0;
      if (rep_d) begin
         add_d = run_nines;
      end else if (acc_d) begin
         add_d = extra;
      end else if (plain_d && cls.is_nine) begin
         add_d = CNT_ONE;
      end
      add_s = '0;
      if (after_point_ff) begin
         if (rep_s) begin
            add_s = run_nines;
         end else if (acc_s) begin
            add_s = extra;
         end else if (plain_s && cls.is_nine) begin
            add_s = CNT_ONE;
         end
      end
      add_l = '0;
      if (acc_l) begin
         add_l = extra;
      end else if (plain_l && cls.is_letter) begin
         add_l = CNT_ONE;
      end
   end

   // Saturating adds: reaching the maximum sets the flag
   always_comb begin
      sum_d = {1'b0, digit_ff} + {1'b0, add_d};
      sum_s = {1'b0, scale_ff} + {1'b0, add_s};
      sum_l = {1'b0, letter_ff} + {1'b0, add_l};
      sat_d = sum_d >= {1'b0, CNT_MAX};
      sat_s = sum_s >= {1'b0, CNT_MAX};
      sat_l = sum_l >= {1'b0, CNT_MAX};
      digit_total  = (sat_d || (acc_d && ev.full)) ? CNT_MAX : sum_d[COUNT_WIDTH-1:0];
      scale_total  = (sat_s || (acc_s && ev.full)) ? CNT_MAX : sum_s[COUNT_WIDTH-1:0];
      letter_total = (sat_l || (acc_l && ev.full)) ? CNT_MAX : sum_l[COUNT_WIDTH-1:0];
      flag_in   = flag_ff || sat_d || sat_s || sat_l || (ev.accept && ev.full);
      saturated = flag_in;
   end

   // Previous-symbol marks and group opening
   always_comb begin
      prev_dig_in = pd_eff;
      if (plain_d) begin
         prev_dig_in = cls.is_nine || (cls.is_open && pd_eff);
      end
      prev_scl_in = ps_eff;
      if (acc_s) begin
         prev_scl_in = 1'b0;
      end else if (plain_s) begin
         prev_scl_in = cls.is_nine || (cls.is_open && ps_eff);
      end
      prev_let_in = pl_eff;
      if (plain_l) begin
         prev_let_in = cls.is_letter || (cls.is_open && pl_eff);
      end
      after_point_in = after_point_ff || (plain_s && cls.is_point);
      opened[GRP_DIG] = plain_d && cls.is_open && pd_eff;
      opened[GRP_SCL] = plain_s && cls.is_open && ps_eff;
      opened[GRP_LET] = plain_l && cls.is_open && pl_eff;
   end

   // Kind from the classifier flags, highest priority first
   always_comb begin
      if (point_seen_ff) begin
         kind = KIND_FLOAT;
      end else if (digit_seen_ff) begin
         kind = KIND_NUMERIC;
      end else if (letter_seen_ff) begin
         kind = KIND_ALNUM;
      end else begin
         kind = KIND_UNKNOWN;
      end
   end

   // Advance per item; drop everything at the end of a string
   always_ff @(posedge clock) begin
      if (reset || (step && cls.is_end)) begin
         letter_seen_ff <= 1'b0;
         digit_seen_ff  <= 1'b0;
         point_seen_ff  <= 1'b0;
         digit_ff       <= '0;
         scale_ff       <= '0;
         letter_ff      <= '0;
         after_point_ff <= 1'b0;
         prev_dig_ff    <= 1'b0;
         prev_scl_ff    <= 1'b0;
         prev_let_ff    <= 1'b0;
         flag_ff        <= 1'b0;
      end else if (step) begin
         letter_seen_ff <= letter_seen_ff || cls.is_letter;
         digit_seen_ff  <= digit_seen_ff || cls.is_numeric;
         point_seen_ff  <= point_seen_ff || cls.is_point;
         digit_ff       <= digit_total;
         scale_ff       <= scale_total;
         letter_ff      <= letter_total;
         after_point_ff <= after_point_in;
         prev_dig_ff    <= prev_dig_in;
         prev_scl_ff    <= prev_scl_in;
         prev_let_ff    <= prev_let_in;
         flag_ff        <= flag_in;
      end
   end

endmodule

// ===== src/picture_clause_analyzer_unit.sv =====
// Picture clause analyzer top level: input register, analysis, result register.
// Depends on pca_pkg, pca_symbol_decode, pca_repeat_group, pca_tally and
// picture_clause_analyzer_unit_defines.svh.
//
//   Channel  Ports                                   Direction
//   req      req_valid, req_stall, req_symbol        in  (one byte per item)
//   rsp      rsp_valid, rsp_stall, rsp_kind,         out (one item per string)
//            rsp_digit_length, rsp_decimal_scale,
//            rsp_text_length, rsp_saturated
//
// One byte is taken per cycle unless a held zero byte stalls the input; the analysis
// of a byte is one pass of logic between the input register and the state and result registers.
// A zero byte passes from the input register into the result register, where its result shows.
// Synchronous reset clears the string state and both valid registers.
// A stalled result only holds back a following zero byte; other bytes
// keep flowing behind it.
`include "picture_clause_analyzer_unit_defines.svh"

module picture_clause_analyzer_unit #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_symbol,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pca_pkg::kind_type   rsp_kind,
   output logic [15:0]         rsp_digit_length,
   output logic [15:0]         rsp_decimal_scale,
   output logic [15:0]         rsp_text_length,
   output logic                rsp_saturated
);
   import pca_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_symbol_ff;
   logic                   out_valid_ff, out_valid_in;
   kind_type               kind_ff;
   logic [15:0]            digit_len_ff, scale_ff, text_len_ff;
   logic                   sat_ff;

   sym_class_type          sym_cls;
   grp_event_type          grp_ev;
   logic [COUNT_WIDTH-1:0] grp_extra, grp_run_nines;
   logic [2:0]             grp_opened;
   kind_type               res_kind;
   logic [COUNT_WIDTH-1:0] res_digit, res_scale, res_letter;
   logic                   res_sat;
   logic                   fire;

   logic                   end_fire, plain_held, rsp_unknown, rsp_empty;

   pca_symbol_decode u_decode (
      .symbol (in_symbol_ff),
      .cls    (sym_cls)
   );

   pca_repeat_group #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_group (
      .clock     (clock),
      .reset     (reset),
      .step      (fire),
      .cls       (sym_cls),
      .opened    (grp_opened),
      .ev        (grp_ev),
      .extra     (grp_extra),
      .run_nines (grp_run_nines)
   );

   pca_tally #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_tally (
      .clock        (clock),
      .reset        (reset),
      .step         (fire),
      .cls          (sym_cls),
      .ev           (grp_ev),
      .extra        (grp_extra),
      .run_nines    (grp_run_nines),
      .opened       (grp_opened),
      .kind         (res_kind),
      .digit_total  (res_digit),
      .scale_total  (res_scale),
      .letter_total (res_letter),
      .saturated    (res_sat)
   );

   // Process the held item unless it is a zero byte with no room for its result
   always_comb begin
      fire      = in_valid_ff && (!sym_cls.is_end || !out_valid_ff || !rsp_stall);
      req_stall = in_valid_ff && !fire;
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire && sym_cls.is_end) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // Valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the input byte
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_symbol_ff <= req_symbol;
      end
   end

   // Load the result at the end of a string
   always_ff @(posedge clock) begin
      if (fire && sym_cls.is_end) begin
         kind_ff      <= res_kind;
         digit_len_ff <= 16'(res_digit);
         scale_ff     <= 16'(res_scale);
         text_len_ff  <= 16'(res_letter);
         sat_ff       <= res_sat;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_digit_length  = digit_len_ff;
   assign rsp_decimal_scale = scale_ff;
   assign rsp_text_length   = text_len_ff;
   assign rsp_saturated     = sat_ff;

   // Terms for the checks below
   assign end_fire    = fire && sym_cls.is_end;
   assign plain_held  = in_valid_ff && !sym_cls.is_end;
   assign rsp_unknown = rsp_valid && (rsp_kind == KIND_UNKNOWN);
   assign rsp_empty   = ((rsp_digit_length | rsp_decimal_scale | rsp_text_length) == 16'd0)
                        && !rsp_saturated;

   // A processed zero byte always shows a result next cycle
   `PCA_ASSERT_NEXT(a_end_gives_result, clock, reset, end_fire, rsp_valid, "end byte lost")

   // Only a zero byte can hold up the input side
   `PCA_ASSERT_IMPL(a_plain_never_stalls, clock, reset, plain_held, !req_stall, "byte stalled")

   // A string with no picture symbols has no counts
   `PCA_ASSERT_IMPL(a_unknown_is_empty, clock, reset, rsp_unknown, rsp_empty, "unknown not empty")

endmodule

// ===== verif/picture_clause_analyzer_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the picture clause analyzer: drives picture strings byte by byte
// and checks every string summary against a predictor of the block kept in this file.
// Depends on pca_pkg and the picture_clause_analyzer_unit top level.
module picture_clause_analyzer_unit_tb;
   import pca_pkg::*;

   localparam int COUNT_MAX = 65535;
   localparam int DRAIN_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      kind_type    kind;
      logic [15:0] digit_length;
      logic [15:0] decimal_scale;
      logic [15:0] text_length;
      logic        saturated;
   } summary_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_symbol = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   kind_type    rsp_kind;
   logic [15:0] rsp_digit_length;
   logic [15:0] rsp_decimal_scale;
   logic [15:0] rsp_text_length;
   logic        rsp_saturated;

   // Predictor state for the picture string in flight
   bit         seen_letter, seen_digit, seen_point;
   int         tally_digits, tally_scale, tally_text;
   bit         past_point, nine_before_dig, nine_before_scl, letter_before;
   logic [2:0] open_mask;
   int         rep_value;
   bit         rep_any;
   int         held_nines;
   bit         held_last_nine;
   bit         hit_max;

   summary_type expected_summaries[$];
   int         error_count = 0;
   int         symbols_sent = 0;
   int         pictures_sent = 0;
   int         summaries_checked = 0;
   int         req_gap_pct = 0;
   int         rsp_stall_pct = 0;
   int         stall_left = 0;

   picture_clause_analyzer_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_symbol        (req_symbol),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_digit_length  (rsp_digit_length),
      .rsp_decimal_scale (rsp_decimal_scale),
      .rsp_text_length   (rsp_text_length),
      .rsp_saturated     (rsp_saturated)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Abort a hung run
   initial begin
      #2ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_picture();
      seen_letter = 1'b0; seen_digit = 1'b0; seen_point = 1'b0;
      tally_digits = 0; tally_scale = 0; tally_text = 0;
      past_point = 1'b0; nine_before_dig = 1'b0; nine_before_scl = 1'b0;
      letter_before = 1'b0; open_mask = '0;
      rep_value = 0; rep_any = 1'b0; held_nines = 0; held_last_nine = 1'b0;
      hit_max = 1'b0;
   endfunction

   // Add with clamp at the count maximum; a clamp marks the summary saturated
   function automatic int clamp_add(int a, int b);
      if (a >= COUNT_MAX || b >= COUNT_MAX - a) begin
         hit_max = 1'b1;
         return COUNT_MAX;
      end
      return a + b;
   endfunction

   // Apply one symbol as a plain symbol to the counts selected by mask
   function automatic void scan_plain(logic [7:0] v, logic [2:0] mask);
      logic [2:0] opened;
      bit         is_letter;
      opened = '0;
      is_letter = (v == CHAR_X || v == CHAR_A || v == CHAR_Z);
      if (mask[GRP_DIG]) begin
         if (v == CHAR_NINE) begin
            tally_digits = clamp_add(tally_digits, 1);
            nine_before_dig = 1'b1;
         end else if (v == CHAR_LPAREN && nine_before_dig) begin
            opened[GRP_DIG] = 1'b1;
         end else begin
            nine_before_dig = 1'b0;
         end
      end
      if (mask[GRP_SCL]) begin
         if (v == CHAR_V) begin
            past_point = 1'b1;
            nine_before_scl = 1'b0;
         end else if (v == CHAR_NINE) begin
            if (past_point)
               tally_scale = clamp_add(tally_scale, 1);
            nine_before_scl = 1'b1;
         end else if (v == CHAR_LPAREN && nine_before_scl) begin
            opened[GRP_SCL] = 1'b1;
         end else begin
            nine_before_scl = 1'b0;
         end
      end
      if (mask[GRP_LET]) begin
         if (is_letter) begin
            tally_text = clamp_add(tally_text, 1);
            letter_before = 1'b1;
         end else if (v == CHAR_LPAREN && letter_before) begin
            opened[GRP_LET] = 1'b1;
         end else begin
            letter_before = 1'b0;
         end
      end
      if (opened != '0) begin
         open_mask = opened;
         rep_value = 0;
         rep_any = 1'b0;
         held_nines = 0;
         held_last_nine = 1'b0;
      end
   endfunction

   // Malformed group: the held digits count as plain symbols
   function automatic void replay_held();
      if (open_mask[GRP_DIG]) begin
         tally_digits = clamp_add(tally_digits, held_nines);
         nine_before_dig = held_last_nine;
      end
      if (open_mask[GRP_SCL]) begin
         if (past_point)
            tally_scale = clamp_add(tally_scale, held_nines);
         nine_before_scl = held_last_nine;
      end
      if (open_mask[GRP_LET])
         letter_before = 1'b0;
      open_mask = '0;
   endfunction

   // Valid group: each open count takes the repeat
   function automatic void accept_repeat();
      bit full;
      int extra;
      full = (rep_value == COUNT_MAX);
      extra = (rep_value > 0) ? rep_value - 1 : 0;
      if (full)
         hit_max = 1'b1;
      if (open_mask[GRP_DIG])
         tally_digits = full ? COUNT_MAX : clamp_add(tally_digits, extra);
      if (open_mask[GRP_SCL]) begin
         if (full)
            tally_scale = COUNT_MAX;
         else if (past_point)
            tally_scale = clamp_add(tally_scale, extra);
         nine_before_scl = 1'b0;
      end
      if (open_mask[GRP_LET])
         tally_text = full ? COUNT_MAX : clamp_add(tally_text, extra);
      open_mask = '0;
   endfunction

   // Advance the predictor by one accepted byte; a zero byte queues a summary
   function automatic void take_symbol(logic [7:0] raw);
      logic [7:0]  v;
      logic [2:0]  closed;
      summary_type s;
      int          d;
      v = raw;
      if (v >= CHAR_LOWER_A && v <= CHAR_LOWER_Z)
         v = v - CASE_OFFSET;
      if (v == CHAR_NUL) begin
         if (open_mask != '0)
            replay_held();
         s.kind = seen_point ? KIND_FLOAT : seen_digit ? KIND_NUMERIC :
                  seen_letter ? KIND_ALNUM : KIND_UNKNOWN;
         s.digit_length = tally_digits[15:0];
         s.decimal_scale = tally_scale[15:0];
         s.text_length = tally_text[15:0];
         s.saturated = hit_max;
         expected_summaries.push_back(s);
         clear_picture();
         return;
      end
      if (v == CHAR_X || v == CHAR_A || v == CHAR_Z)
         seen_letter = 1'b1;
      if (v == CHAR_NINE || v == CHAR_S || v == CHAR_V) begin
         seen_digit = 1'b1;
         if (v == CHAR_V)
            seen_point = 1'b1;
      end
      if (open_mask != '0) begin
         closed = ~open_mask;
         if (v >= CHAR_ZERO && v <= CHAR_NINE) begin
            d = int'(v - CHAR_ZERO);
            if (rep_value > (COUNT_MAX - d) / 10)
               rep_value = COUNT_MAX;
            else
               rep_value = rep_value * 10 + d;
            rep_any = 1'b1;
            if (v == CHAR_NINE && held_nines < COUNT_MAX)
               held_nines++;
            held_last_nine = (v == CHAR_NINE);
            scan_plain(v, closed);
            return;
         end
         if (v == CHAR_RPAREN && rep_any) begin
            accept_repeat();
            scan_plain(v, closed);
            return;
         end
         replay_held();
      end
      scan_plain(v, 3'b111);
   endfunction

   // ---------------------------------------------------------------- monitor and checker

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Predict on each accepted byte, then match each accepted summary
   always @(posedge clock) begin
      summary_type want;
      if (!reset) begin
         if (req_valid && req_stall === 1'b0)
            take_symbol(req_symbol);
         if (rsp_valid !== 1'b0 && rsp_stall == 1'b0) begin
            if (expected_summaries.size() == 0) begin
               $error("summary arrived with none expected");
               error_count++;
            end else begin
               want = expected_summaries.pop_front();
               check_field("kind", 16'(want.kind), 16'(rsp_kind));
               check_field("digit_length", want.digit_length, rsp_digit_length);
               check_field("decimal_scale", want.decimal_scale, rsp_decimal_scale);
               check_field("text_length", want.text_length, rsp_text_length);
               check_field("saturated", 16'(want.saturated), 16'(rsp_saturated));
               summaries_checked++;
            end
         end
      end
   end

   // Hold off the result side in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (rsp_stall_pct > 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- stimulus

   // Send one item; returns in the step at which it was taken
   task automatic send_symbol(input logic [7:0] sym);
      if (req_gap_pct > 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_symbol <= sym;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      symbols_sent++;
      if (sym == CHAR_NUL)
         pictures_sent++;
   endtask

   task automatic send_picture(input string text);
      for (int i = 0; i < text.len(); i++)
         send_symbol(text[i]);
      send_symbol(CHAR_NUL);
   endtask

   function automatic logic [7:0] random_case(logic [7:0] c);
      return $urandom_range(0, 1) ? c : (c | CASE_OFFSET);
   endfunction

   function automatic logic [7:0] random_letter();
      case ($urandom_range(0, 2))
         0: return random_case(CHAR_X);
         1: return random_case(CHAR_A);
         default: return random_case(CHAR_Z);
      endcase
   endfunction

   function automatic void pick_idling();
      int levels[4] = '{0, 10, 30, 60};
      req_gap_pct = levels[$urandom_range(0, 3)];
      rsp_stall_pct = levels[$urandom_range(0, 3)];
   endfunction

   // Send "(digits)" with a mostly small repeat; some groups come out malformed
   task automatic send_repeat_group();
      string digits;
      int    pick;
      send_symbol(CHAR_LPAREN);
      pick = $urandom_range(0, 15);
      if (pick == 0)
         digits = "";
      else if (pick == 1)
         digits = "65535";
      else if (pick == 2)
         digits = $sformatf("%0d", $urandom_range(10000, 99999));
      else if (pick == 3)
         digits = $sformatf("0%0d", $urandom_range(0, 9));
      else
         digits = $sformatf("%0d", $urandom_range(0, 20));
      for (int i = 0; i < digits.len(); i++)
         send_symbol(digits[i]);
      if ($urandom_range(0, 7) == 0)
         send_symbol(($urandom_range(0, 1) != 0) ? CHAR_LPAREN : random_letter());
      else
         send_symbol(CHAR_RPAREN);
   endtask

   task automatic send_token();
      case ($urandom_range(0, 9))
         0, 1, 2: send_symbol(CHAR_NINE);
         3: send_symbol(random_letter());
         4: send_symbol(random_case(CHAR_V));
         5: send_symbol(random_case(CHAR_S));
         6: begin
            send_symbol(CHAR_NINE);
            send_repeat_group();
         end
         7: begin
            send_symbol(random_letter());
            send_repeat_group();
         end
         8: send_repeat_group();
         default: begin
            case ($urandom_range(0, 3))
               0: send_symbol(CHAR_RPAREN);
               1: send_symbol(CHAR_LPAREN);
               2: send_symbol(CHAR_ZERO + 8'($urandom_range(0, 8)));
               default: send_symbol(8'($urandom_range(1, 255)));
            endcase
         end
      endcase
   endtask

   // One string of random tokens, or of raw bytes when noisy
   task automatic send_random_picture(input int tokens, input bit noisy);
      for (int i = 0; i < tokens; i++) begin
         if (noisy)
            send_symbol(8'($urandom_range(1, 255)));
         else
            send_token();
      end
      send_symbol(CHAR_NUL);
   endtask

   // ---------------------------------------------------------------- tests

   // Empty string, each kind, case folding and a high byte
   task automatic test_kinds();
      send_picture("");
      send_symbol(8'hFF);
      send_picture("az");
      send_picture("s");
      send_picture("9v9");
   endtask

   // Chained letter groups, zero repeat, empty group, group cut by the end byte
   task automatic test_repeat_groups();
      send_picture("x(2)(0)9()9(3");
   endtask

   // Repeat that hits the count maximum
   task automatic test_saturation();
      send_picture("9(65535)");
   endtask

   // Mostly well-formed strings with random idling on both sides
   task automatic test_random_pictures();
      int target;
      target = symbols_sent + 750;
      while (symbols_sent < target) begin
         if ($urandom_range(0, 3) == 0)
            pick_idling();
         send_random_picture($urandom_range(1, 10), 1'b0);
      end
   endtask

   // Strings of arbitrary bytes
   task automatic test_random_noise();
      int target;
      target = symbols_sent + 150;
      while (symbols_sent < target) begin
         pick_idling();
         send_random_picture($urandom_range(1, 12), 1'b1);
      end
   endtask

   // Back-to-back strings with no idling at all
   task automatic test_steady_stream();
      int target;
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      target = symbols_sent + 100;
      while (symbols_sent < target)
         send_random_picture($urandom_range(1, 8), $urandom_range(0, 4) == 0);
   endtask

   initial begin
      int waited;
      clear_picture();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      req_gap_pct = 20;
      rsp_stall_pct = 20;
      test_kinds();
      test_repeat_groups();
      test_saturation();
      test_random_pictures();
      test_random_noise();
      test_steady_stream();
      req_valid <= 1'b0;

      // Drain outstanding summaries, then let the pipeline settle
      waited = 0;
      while (expected_summaries.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_summaries.size() != 0) begin
         $error("%0d summaries never arrived", expected_summaries.size());
         error_count++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d picture strings; checked %0d summaries.",
               symbols_sent, pictures_sent, summaries_checked);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
